[hw/rtl/color_opponency_core_assert.svh]
// Assertion macros used by the colour opponency top level.
`ifndef COLOR_OPPONENCY_CORE_ASSERT_SVH
`define COLOR_OPPONENCY_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define COC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define COC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/coc_pkg.sv]
// Package with the shared types and constants of the colour opponency block.
package coc_pkg;

  localparam int unsigned FRAC_BITS_DEF = 14;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned OUT_W         = 16;
  localparam int          OUT_MAX       = 32767;
  localparam int          OUT_MIN       = -32768;
  localparam logic [PIX_W-1:0] DARK_THRESHOLD_RST = 8'd26;

  // Data carried along the divider chain alongside the quotient bits.
  typedef struct packed {
    logic [PIX_W:0]   rem_rg;
    logic [PIX_W:0]   rem_by;
    logic [PIX_W-1:0] den;
    logic             neg_rg;
    logic             neg_by;
    logic             last;
  } coc_div_t;

endpackage

[hw/rtl/coc_front.sv]
// Input stage: brightest channel, dark test, signed differences and their magnitudes.
module coc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [coc_pkg::PIX_W-1:0]   red_i,
  input  logic [coc_pkg::PIX_W-1:0]   green_i,
  input  logic [coc_pkg::PIX_W-1:0]   blue_i,
  input  logic                        last_in_i,
  input  logic [coc_pkg::PIX_W-1:0]   dark_threshold_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output coc_pkg::coc_div_t           data_o
);
  import coc_pkg::*;

  logic             valid_q;
  coc_div_t         data_q;
  coc_div_t         data_d;
  logic [PIX_W-1:0] mx_rg;
  logic [PIX_W-1:0] mn_rg;
  logic [PIX_W-1:0] mx;
  logic [PIX_W-1:0] mag_rg;
  logic [PIX_W-1:0] mag_by;
  logic             dark;

  always_comb begin
    mx_rg  = (red_i > green_i) ? red_i : green_i;
    mn_rg  = (red_i < green_i) ? red_i : green_i;
    mx     = (blue_i > mx_rg) ? blue_i : mx_rg;
    dark   = (mx == '0) || (mx < dark_threshold_i);
    data_d.neg_rg = red_i < green_i;
    data_d.neg_by = blue_i < mn_rg;
    mag_rg = data_d.neg_rg ? (green_i - red_i) : (red_i - green_i);
    mag_by = data_d.neg_by ? (mn_rg - blue_i) : (blue_i - mn_rg);
    data_d.last = last_in_i;
    if (dark) begin
      data_d.rem_rg = '0;
      data_d.rem_by = '0;
      data_d.den    = PIX_W'(1);
    end else begin
      data_d.rem_rg = {1'b0, mag_rg};
      data_d.rem_by = {1'b0, mag_by};
      data_d.den    = mx;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hw/rtl/coc_cell.sv]
// Divider cell: one restoring step per lane, producing one quotient bit each.
module coc_cell #(
  parameter int unsigned QW = coc_pkg::FRAC_BITS_DEF + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  coc_pkg::coc_div_t data_i,
  input  logic [QW-1:0]     q_rg_i,
  input  logic [QW-1:0]     q_by_i,
  output logic              valid_o,
  input  logic              ready_i,
  output coc_pkg::coc_div_t data_o,
  output logic [QW-1:0]     q_rg_o,
  output logic [QW-1:0]     q_by_o
);
  import coc_pkg::*;

  logic             valid_q;
  coc_div_t         data_q;
  coc_div_t         data_d;
  logic [QW-1:0]    q_rg_q;
  logic [QW-1:0]    q_by_q;
  logic [QW-1:0]    q_rg_d;
  logic [QW-1:0]    q_by_d;
  logic [PIX_W:0]   den_ext;
  logic [PIX_W:0]   sub_rg;
  logic [PIX_W:0]   sub_by;
  logic             ge_rg;
  logic             ge_by;
  logic [PIX_W-1:0] rest_rg;
  logic [PIX_W-1:0] rest_by;

  always_comb begin
    den_ext = {1'b0, data_i.den};
    ge_rg   = data_i.rem_rg >= den_ext;
    ge_by   = data_i.rem_by >= den_ext;
    sub_rg  = data_i.rem_rg - den_ext;
    sub_by  = data_i.rem_by - den_ext;
    rest_rg = ge_rg ? sub_rg[PIX_W-1:0] : data_i.rem_rg[PIX_W-1:0];
    rest_by = ge_by ? sub_by[PIX_W-1:0] : data_i.rem_by[PIX_W-1:0];
    data_d        = data_i;
    data_d.rem_rg = {rest_rg, 1'b0};
    data_d.rem_by = {rest_by, 1'b0};
    q_rg_d        = {q_rg_i[QW-2:0], ge_rg};
    q_by_d        = {q_by_i[QW-2:0], ge_by};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
      q_rg_q <= q_rg_d;
      q_by_q <= q_by_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign q_rg_o  = q_rg_q;
  assign q_by_o  = q_by_q;

endmodule

[hw/rtl/color_opponency_core.sv]
// Top level of the colour opponency block: input stage, divider chain and output register.
//
// One RGB pixel (8-bit channels plus a last flag) is taken per transfer on the input
// channel (valid_i, stall_o) and gives one transfer on the output channel (valid_o,
// stall_i) carrying red_green_o, blue_yellow_o and last_out_o in the same order.
// Results are signed fixed point with FRAC_BITS fraction bits, truncated toward zero
// and saturated to 16 bits; a pixel whose brightest channel is below the dark
// threshold, or is zero, gives zero on both results.
// The dark threshold is written through cfg_valid_i/cfg_data_i; cfg_ready_o is always
// high and the write must only happen while the block holds no pixel.
// The path from input transfer to output valid runs through one input stage, a chain of
// FRAC_BITS + 1 divider cells each resolving one quotient bit of both results, and the
// output register. One pixel is accepted every cycle while stall_o is low.
// Reset empties every stage and sets the dark threshold to 26.
// When the receiver stalls, the output holds and the chain fills; stall_o rises only
// once every stage holds a pixel, and drops in the cycle the output is taken.
module color_opponency_core #(
  parameter int unsigned FRAC_BITS = coc_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [coc_pkg::PIX_W-1:0] red_i,
  input  logic [coc_pkg::PIX_W-1:0] green_i,
  input  logic [coc_pkg::PIX_W-1:0] blue_i,
  input  logic                      last_in_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [coc_pkg::OUT_W-1:0] red_green_o,
  output logic [coc_pkg::OUT_W-1:0] blue_yellow_o,
  output logic                      last_out_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [coc_pkg::PIX_W-1:0] cfg_data_i
);
  import coc_pkg::*;

  localparam int unsigned QW      = FRAC_BITS + 1;
  localparam int unsigned SW      = QW + 1;
  localparam int unsigned EW      = (SW > OUT_W) ? SW : OUT_W;
  localparam int          OUT_LIM = (FRAC_BITS >= 15) ? OUT_MAX + 1 : (1 << FRAC_BITS);

  logic [PIX_W-1:0] dark_threshold_q;

  logic             chain_valid [QW+1];
  logic             chain_ready [QW+2];
  coc_div_t         chain_data  [QW+1];
  logic [QW-1:0]    chain_q_rg  [QW+1];
  logic [QW-1:0]    chain_q_by  [QW+1];

  logic                     out_ready;
  logic                     out_valid_q;
  logic [OUT_W-1:0]         red_green_q;
  logic [OUT_W-1:0]         blue_yellow_q;
  logic                     last_q;
  logic [OUT_W-1:0]         red_green_d;
  logic [OUT_W-1:0]         blue_yellow_d;
  logic signed [EW-1:0]     val_rg;
  logic signed [EW-1:0]     val_by;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_threshold_q <= DARK_THRESHOLD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dark_threshold_q <= cfg_data_i;
    end
  end

  coc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_i),
    .ready_o          (chain_ready[0]),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .last_in_i        (last_in_i),
    .dark_threshold_i (dark_threshold_q),
    .valid_o          (chain_valid[0]),
    .ready_i          (chain_ready[1]),
    .data_o           (chain_data[0])
  );

  assign stall_o          = !chain_ready[0];
  assign chain_q_rg[0]    = '0;
  assign chain_q_by[0]    = '0;
  assign chain_ready[QW+1] = out_ready;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    coc_cell #(
      .QW (QW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[i]),
      .ready_o (chain_ready[i+1]),
      .data_i  (chain_data[i]),
      .q_rg_i  (chain_q_rg[i]),
      .q_by_i  (chain_q_by[i]),
      .valid_o (chain_valid[i+1]),
      .ready_i (chain_ready[i+2]),
      .data_o  (chain_data[i+1]),
      .q_rg_o  (chain_q_rg[i+1]),
      .q_by_o  (chain_q_by[i+1])
    );
  end

  always_comb begin
    val_rg = chain_data[QW].neg_rg ? -EW'(chain_q_rg[QW]) : EW'(chain_q_rg[QW]);
    val_by = chain_data[QW].neg_by ? -EW'(chain_q_by[QW]) : EW'(chain_q_by[QW]);
  end

  if (EW > OUT_W) begin : g_sat
    localparam logic signed [EW-1:0] SAT_HI = EW'(OUT_MAX);
    localparam logic signed [EW-1:0] SAT_LO = EW'(OUT_MIN);
    always_comb begin
      priority if (val_rg > SAT_HI) begin
        red_green_d = OUT_W'(OUT_MAX);
      end else if (val_rg < SAT_LO) begin
        red_green_d = OUT_W'(OUT_MIN);
      end else begin
        red_green_d = val_rg[OUT_W-1:0];
      end
      priority if (val_by > SAT_HI) begin
        blue_yellow_d = OUT_W'(OUT_MAX);
      end else if (val_by < SAT_LO) begin
        blue_yellow_d = OUT_W'(OUT_MIN);
      end else begin
        blue_yellow_d = val_by[OUT_W-1:0];
      end
    end
  end else begin : g_nosat
    assign red_green_d   = val_rg[OUT_W-1:0];
    assign blue_yellow_d = val_by[OUT_W-1:0];
  end

  assign out_ready = !out_valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= chain_valid[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_valid[QW] && out_ready) begin
      red_green_q   <= red_green_d;
      blue_yellow_q <= blue_yellow_d;
      last_q        <= chain_data[QW].last;
    end
  end

  assign valid_o       = out_valid_q;
  assign red_green_o   = red_green_q;
  assign blue_yellow_o = blue_yellow_q;
  assign last_out_o    = last_q;

`include "color_opponency_core_assert.svh"

  `COC_ASSERT_NOW(a_stall_only_when_full, stall_o, valid_o && stall_i, "input stalled while output free")
  `COC_ASSERT_NOW(a_rg_bound, valid_o, ($signed(red_green_o) <= OUT_LIM) && ($signed(red_green_o) >= -OUT_LIM), "red_green out of range")
  `COC_ASSERT_NOW(a_by_bound, valid_o, ($signed(blue_yellow_o) <= OUT_LIM) && ($signed(blue_yellow_o) >= -OUT_LIM), "blue_yellow out of range")
  `COC_ASSERT_NEXT(a_out_fill, !valid_o && chain_valid[QW], valid_o, "finished pixel not moved to output")

endmodule

[tb/color_opponency_checker.sv]
// Checker that predicts the opponency results of each accepted pixel and compares them.
module color_opponency_checker #(
  parameter int unsigned FRAC_BITS = coc_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      pix_valid_i,
  input  logic                      pix_stall_i,
  input  logic [coc_pkg::PIX_W-1:0] red_i,
  input  logic [coc_pkg::PIX_W-1:0] green_i,
  input  logic [coc_pkg::PIX_W-1:0] blue_i,
  input  logic                      last_in_i,
  input  logic                      res_valid_i,
  input  logic                      res_stall_i,
  input  logic [coc_pkg::OUT_W-1:0] red_green_i,
  input  logic [coc_pkg::OUT_W-1:0] blue_yellow_i,
  input  logic                      last_out_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [coc_pkg::PIX_W-1:0] cfg_data_i,
  output int                        pending_o,
  output int                        errors_o,
  output int                        checked_o
);
  import coc_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] red_green;
    logic [OUT_W-1:0] blue_yellow;
    logic             last;
  } opponency_t;

  opponency_t       expected_opp_q [$];
  logic [PIX_W-1:0] threshold_q;
  int               accepted_q;
  int               checked_q;
  int               errors_q;

  assign pending_o = accepted_q - checked_q;
  assign errors_o  = errors_q;
  assign checked_o = checked_q;

  function automatic logic [OUT_W-1:0] scaled_quotient(input int num, input int den);
    longint scaled;
    longint quot;
    scaled = longint'(num) * (longint'(1) <<< FRAC_BITS);
    quot   = scaled / longint'(den);
    if (quot > OUT_MAX) quot = OUT_MAX;
    if (quot < OUT_MIN) quot = OUT_MIN;
    return quot[OUT_W-1:0];
  endfunction

  function automatic opponency_t predict_opponency(input logic [PIX_W-1:0] r,
                                                   input logic [PIX_W-1:0] g,
                                                   input logic [PIX_W-1:0] b,
                                                   input logic             last,
                                                   input logic [PIX_W-1:0] thresh);
    int         brightest;
    int         dimmer;
    opponency_t res;
    brightest = (r > g) ? int'(r) : int'(g);
    dimmer    = (r < g) ? int'(r) : int'(g);
    if (int'(b) > brightest) brightest = int'(b);
    res.last = last;
    if (brightest == 0 || brightest < int'(thresh)) begin
      res.red_green   = '0;
      res.blue_yellow = '0;
    end else begin
      res.red_green   = scaled_quotient(int'(r) - int'(g), brightest);
      res.blue_yellow = scaled_quotient(int'(b) - dimmer, brightest);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    opponency_t got;
    opponency_t want;
    int         bad;
    if (!rst_ni) begin
      expected_opp_q.delete();
      threshold_q <= DARK_THRESHOLD_RST;
      accepted_q  <= 0;
      checked_q   <= 0;
      errors_q    <= 0;
    end else begin
      bad = 0;
      if (cfg_valid_i && cfg_ready_i) begin
        threshold_q <= cfg_data_i;
      end
      if (pix_valid_i && !pix_stall_i) begin
        expected_opp_q.insert(expected_opp_q.size(),
                              predict_opponency(red_i, green_i, blue_i, last_in_i,
                                                threshold_q));
        accepted_q <= accepted_q + 1;
      end
      if (res_valid_i && !res_stall_i) begin
        got = '{red_green_i, blue_yellow_i, last_out_i};
        if (expected_opp_q.size() == 0) begin
          $display("%0t: unexpected result transfer: red_green %0d, blue_yellow %0d, last %0b",
                   $time, $signed(got.red_green), $signed(got.blue_yellow), got.last);
          bad++;
        end else begin
          want = expected_opp_q.pop_front();
          checked_q <= checked_q + 1;
          if (got.red_green !== want.red_green) begin
            $display("%0t: red_green expected %0d, got %0d", $time,
                     $signed(want.red_green), $signed(got.red_green));
            bad++;
          end
          if (got.blue_yellow !== want.blue_yellow) begin
            $display("%0t: blue_yellow expected %0d, got %0d", $time,
                     $signed(want.blue_yellow), $signed(got.blue_yellow));
            bad++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last_out expected %0b, got %0b", $time, want.last, got.last);
            bad++;
          end
        end
      end
      if (bad != 0) errors_q <= errors_q + bad;
    end
  end

endmodule

[tb/tb_top.sv]
// Top of the colour opponency testbench: clock, reset, pixel stimulus and verdict.
module tb_top;
  import coc_pkg::*;

  localparam int unsigned CYCLE_LIMIT        = 200000;
  localparam int unsigned DRAIN_CYCLES       = FRAC_BITS_DEF + 12;
  localparam int unsigned PIXELS_PER_SETTING = 240;

  logic             clk_i;
  logic             rst_ni;
  logic             valid_i;
  logic             stall_o;
  logic [PIX_W-1:0] red_i;
  logic [PIX_W-1:0] green_i;
  logic [PIX_W-1:0] blue_i;
  logic             last_in_i;
  logic             valid_o;
  logic             stall_i;
  logic [OUT_W-1:0] red_green_o;
  logic [OUT_W-1:0] blue_yellow_o;
  logic             last_out_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [PIX_W-1:0] cfg_data_i;

  logic             no_idle;
  logic [PIX_W-1:0] cur_thresh;
  int unsigned      cycle_cnt = 0;
  int unsigned      pixels_sent;
  int               pending;
  int               errors;
  int               checked;

  color_opponency_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .last_in_i     (last_in_i),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .red_green_o   (red_green_o),
    .blue_yellow_o (blue_yellow_o),
    .last_out_o    (last_out_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  color_opponency_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_valid_i   (valid_i),
    .pix_stall_i   (stall_o),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .last_in_i     (last_in_i),
    .res_valid_i   (valid_o),
    .res_stall_i   (stall_i),
    .red_green_i   (red_green_o),
    .blue_yellow_i (blue_yellow_o),
    .last_out_i    (last_out_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending),
    .errors_o      (errors),
    .checked_o     (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    stall_i <= !no_idle && ($urandom_range(0, 99) < 13);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.", cycle_cnt,
               pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b, input logic last);
    while (!no_idle && $urandom_range(0, 99) < 13) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i   <= 1'b1;
    red_i     <= r;
    green_i   <= g;
    blue_i    <= b;
    last_in_i <= last;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    pixels_sent++;
  endtask

  task automatic send_random_pixel();
    logic [PIX_W-1:0] ch [3];
    int               kind;
    int               peak;
    int               top_ch;
    kind  = $urandom_range(0, 99);
    ch[0] = PIX_W'($urandom_range(0, 255));
    ch[1] = PIX_W'($urandom_range(0, 255));
    ch[2] = PIX_W'($urandom_range(0, 255));
    if (kind < 20) begin
      peak = int'(cur_thresh) + int'($urandom_range(0, 3)) - 2;
      if (peak < 0) peak = 0;
      if (peak > 255) peak = 255;
      top_ch = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        ch[i] = (i == top_ch) ? PIX_W'(peak) : PIX_W'($urandom_range(0, peak));
      end
    end else if (kind < 35) begin
      ch[1] = ch[0];
      if ($urandom_range(0, 1) == 1) ch[2] = ch[0];
    end else if (kind < 50) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 2))
          0: ch[i] = 8'd0;
          1: ch[i] = 8'd255;
          default: ;
        endcase
      end
    end else if (kind < 60) begin
      for (int i = 0; i < 3; i++) ch[i] = PIX_W'($urandom_range(0, 3));
    end
    send_pixel(ch[0], ch[1], ch[2], $urandom_range(0, 9) == 0);
  endtask

  // The threshold is only changed once every pixel in flight has come out.
  task automatic write_threshold(input logic [PIX_W-1:0] value);
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_thresh = value;
  endtask

  initial begin
    logic [PIX_W-1:0] settings [6];
    rst_ni      = 1'b0;
    valid_i     = 1'b0;
    red_i       = '0;
    green_i     = '0;
    blue_i      = '0;
    last_in_i   = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    no_idle     = 1'b0;
    cur_thresh  = DARK_THRESHOLD_RST;
    pixels_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels under the reset threshold of 26.
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
    send_pixel(8'd0,   8'd0,   8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd0,   1'b0);
    send_pixel(8'd25,  8'd0,   8'd0,   1'b1);
    send_pixel(8'd26,  8'd0,   8'd0,   1'b0);
    send_pixel(8'd0,   8'd25,  8'd10,  1'b0);
    send_pixel(8'd0,   8'd0,   8'd26,  1'b0);
    send_pixel(8'd33,  8'd100, 8'd0,   1'b0);
    send_pixel(8'd100, 8'd33,  8'd7,   1'b0);
    send_pixel(8'd200, 8'd199, 8'd201, 1'b0);
    send_pixel(8'd1,   8'd2,   8'd3,   1'b0);
    send_pixel(8'd128, 8'd64,  8'd255, 1'b1);
    send_pixel(8'd170, 8'd85,  8'd127, 1'b0);
    send_pixel(8'd254, 8'd1,   8'd128, 1'b0);
    send_pixel(8'd255, 8'd254, 8'd0,   1'b0);
    send_pixel(8'd7,   8'd91,  8'd53,  1'b0);
    send_pixel(8'd255, 8'd0,   8'd255, 1'b1);
    repeat (PIXELS_PER_SETTING) send_random_pixel();

    settings[0] = 8'd1;
    settings[1] = 8'd255;
    settings[2] = 8'd0;
    settings[3] = PIX_W'($urandom_range(2, 254));
    settings[4] = PIX_W'($urandom_range(2, 254));
    settings[5] = DARK_THRESHOLD_RST;
    foreach (settings[i]) begin
      write_threshold(settings[i]);
      no_idle <= (i == 3);
      repeat (PIXELS_PER_SETTING) send_random_pixel();
    end

    valid_i <= 1'b0;
    no_idle <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d pixels and checked %0d results under seven dark thresholds,",
             pixels_sent, checked);
    $display("including 0, 1, 255 and the reset value, with random gaps and stalls.");
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
